### rtl/core/cdq_pkg.sv
// Shared types and constants for the circular double-ended queue.
// Holds opcode and status codes, the command record and the opcode decoder.
// No dependencies.
package cdq_pkg;

    localparam int DATA_W     = 32;
    localparam int OPC_W      = 3;
    localparam int STATUS_W   = 2;
    localparam int DEPTH_DEF  = 16;
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

    // opcode field codes
    localparam logic [OPC_W-1:0] OPC_PUSH_HEAD = 3'd0;
    localparam logic [OPC_W-1:0] OPC_PUSH_TAIL = 3'd1;
    localparam logic [OPC_W-1:0] OPC_POP_HEAD  = 3'd2;
    localparam logic [OPC_W-1:0] OPC_POP_TAIL  = 3'd3;
    localparam logic [OPC_W-1:0] OPC_LIST      = 3'd4;

    // status field codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        OP_PUSH_HEAD,
        OP_PUSH_TAIL,
        OP_POP_HEAD,
        OP_POP_TAIL,
        OP_LIST
    } t_op;

    typedef struct packed {
        t_op                     op;
        logic signed [DATA_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic known;
        t_op  op;
    } t_class;

    // Map an opcode to a back-end operation; unknown codes are dropped.
    function automatic t_class classify(input logic [OPC_W-1:0] opc);
        t_class c;
        c.known = 1'b1;
        c.op    = OP_PUSH_HEAD;
        case (opc)
            OPC_PUSH_HEAD: c.op = OP_PUSH_HEAD;
            OPC_PUSH_TAIL: c.op = OP_PUSH_TAIL;
            OPC_POP_HEAD:  c.op = OP_POP_HEAD;
            OPC_POP_TAIL:  c.op = OP_POP_TAIL;
            OPC_LIST:      c.op = OP_LIST;
            default:       c.known = 1'b0;
        endcase
        return c;
    endfunction

endpackage

### rtl/core/cdq_front.sv
// Front end: accepts input requests, decodes the opcode and drops unknown codes.
// Feeds decoded commands to the command queue. Uses cdq_pkg.
module cdq_front
    import cdq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [OPC_W-1:0]         i_opcode,
    input  logic signed [DATA_W-1:0] i_push_value,
    output logic                     o_q_wr,
    output t_cmd                     o_q_cmd,
    input  logic                     i_q_full
);

    logic   r_valid;
    logic   n_valid;
    t_cmd   r_cmd;
    t_class w_class;
    logic   w_accept;

    // hold the request while the queue is full
    assign o_in_stall = r_valid && i_q_full;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_class    = classify(i_opcode);

    always_comb begin
        if (w_accept) begin
            n_valid = w_class.known;
        end else begin
            n_valid = r_valid && i_q_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // capture the decoded command
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd.op    <= w_class.op;
            r_cmd.value <= i_push_value;
        end
    end

    assign o_q_wr  = r_valid && !i_q_full;
    assign o_q_cmd = r_cmd;

endmodule

### rtl/core/cdq_cmd_fifo.sv
// Short command queue between the front end and the back end.
// Lets either side stall on its own. Uses cdq_pkg.
module cdq_cmd_fifo
    import cdq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_cmd i_wr_cmd,
    output logic o_full,
    output logic o_rd_valid,
    output t_cmd o_rd_cmd,
    input  logic i_rd_pop
);

    t_cmd               r_mem [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] r_wr_ptr;
    logic [CMDQ_AW-1:0] r_rd_ptr;
    logic [CMDQ_CW-1:0] r_count;
    logic               w_wr;
    logic               w_rd;

    assign o_full     = (r_count == CMDQ_CW'(CMDQ_DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_cmd   = r_mem[r_rd_ptr];
    assign w_wr       = i_wr && !o_full;
    assign w_rd       = i_rd_pop && o_rd_valid;

    // advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // store the entry
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

endmodule

### rtl/core/cdq_back.sv
// Back end: runs commands on the circular buffer and drives the result register.
// Holds the buffer memory, head and tail indices and the empty flag. Uses cdq_pkg.
module cdq_back
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cmd_valid,
    input  t_cmd                       i_cmd,
    output logic                       o_cmd_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [STATUS_W-1:0]        o_status,
    output logic signed [DATA_W-1:0]   o_out_value,
    output logic                       o_last
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_LIST
    } t_state;

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] prev_slot(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
    endfunction

    logic [DATA_W-1:0]   r_mem [DEPTH];
    logic [DATA_W-1:0]   r_rd_data;

    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_head, n_head;
    logic [IDX_W-1:0]    r_tail, n_tail;
    logic                r_empty, n_empty;
    logic [IDX_W-1:0]    r_walk, n_walk;
    logic                r_at_tail, n_at_tail;
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [DATA_W-1:0]   r_value, n_value;
    logic                r_last, n_last;

    logic                w_out_free;
    logic                w_full;
    logic                w_we;
    logic [IDX_W-1:0]    w_wa;
    logic                w_re;
    logic [IDX_W-1:0]    w_ra;
    logic [IDX_W-1:0]    w_slot;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_full     = !r_empty && (r_head == next_slot(r_tail));

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_empty     = r_empty;
        n_walk      = r_walk;
        n_at_tail   = r_at_tail;
        n_out_valid = r_out_valid && i_out_stall;
        n_status    = r_status;
        n_value     = r_value;
        n_last      = r_last;
        o_cmd_pop   = 1'b0;
        w_we        = 1'b0;
        w_wa        = '0;
        w_re        = 1'b0;
        w_ra        = r_head;
        w_slot      = '0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && w_out_free) begin
                    o_cmd_pop   = 1'b1;
                    n_out_valid = 1'b1;
                    n_status    = ST_OK;
                    n_value     = '0;
                    n_last      = 1'b1;
                    case (i_cmd.op)
                        OP_PUSH_HEAD, OP_PUSH_TAIL: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                w_we = 1'b1;
                                if (r_empty) begin
                                    // first entry always lands in slot zero
                                    n_head  = '0;
                                    n_tail  = '0;
                                    n_empty = 1'b0;
                                    w_wa    = '0;
                                end else if (i_cmd.op == OP_PUSH_HEAD) begin
                                    w_slot = prev_slot(r_head);
                                    n_head = w_slot;
                                    w_wa   = w_slot;
                                end else begin
                                    w_slot = next_slot(r_tail);
                                    n_tail = w_slot;
                                    w_wa   = w_slot;
                                end
                            end
                        end
                        OP_POP_HEAD, OP_POP_TAIL: begin
                            if (r_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                // read the slot now; S_POP emits it once the output is free
                                n_out_valid = 1'b0;
                                w_re        = 1'b1;
                                w_ra        = (i_cmd.op == OP_POP_HEAD) ? r_head : r_tail;
                                n_state     = S_POP;
                                if (r_head == r_tail) begin
                                    n_empty = 1'b1;
                                    n_head  = '0;
                                    n_tail  = '0;
                                end else if (i_cmd.op == OP_POP_HEAD) begin
                                    n_head = next_slot(r_head);
                                end else begin
                                    n_tail = prev_slot(r_tail);
                                end
                            end
                        end
                        OP_LIST: begin
                            if (r_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_out_valid = 1'b0;
                                w_re        = 1'b1;
                                w_ra        = r_head;
                                n_walk      = r_head;
                                n_at_tail   = (r_head == r_tail);
                                n_state     = S_LIST;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b0;
                        end
                    endcase
                end
            end
            S_POP: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_OK;
                    n_value     = r_rd_data;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_LIST: begin
                // emit one entry per free output slot, walking head to tail
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_OK;
                    n_value     = r_rd_data;
                    n_last      = r_at_tail;
                    if (r_at_tail) begin
                        n_state = S_IDLE;
                    end else begin
                        w_slot    = next_slot(r_walk);
                        n_walk    = w_slot;
                        w_re      = 1'b1;
                        w_ra      = w_slot;
                        n_at_tail = (w_slot == r_tail);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_empty     <= 1'b1;
            r_walk      <= '0;
            r_at_tail   <= 1'b0;
            r_out_valid <= 1'b0;
            r_status    <= ST_OK;
            r_value     <= '0;
            r_last      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_empty     <= n_empty;
            r_walk      <= n_walk;
            r_at_tail   <= n_at_tail;
            r_out_valid <= n_out_valid;
            r_status    <= n_status;
            r_value     <= n_value;
            r_last      <= n_last;
        end
    end

    // buffer memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= i_cmd.value;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_ra];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_out_value = r_value;
    assign o_last      = r_last;

endmodule

### rtl/core/circular_double_ended_queue.sv
// Circular double-ended queue. Synchronous active-low reset empties the queue and both
// indices return to 0; buffer contents are undefined until written. Pop and list
// results also pass the buffer read register. The back end takes one push per cycle
// while the output is not stalled; a pop holds it in S_POP until the value is emitted,
// and a list emits one entry per cycle from the buffer read port while not stalled.
module circular_double_ended_queue
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [OPC_W-1:0]         i_opcode,
    input  logic signed [DATA_W-1:0] i_push_value,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [STATUS_W-1:0]      o_status,
    output logic signed [DATA_W-1:0] o_out_value,
    output logic                     o_last
);

    logic w_q_wr;
    t_cmd w_q_wr_cmd;
    logic w_q_full;
    logic w_cmd_valid;
    t_cmd w_cmd;
    logic w_cmd_pop;

    cdq_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_opcode     (i_opcode),
        .i_push_value (i_push_value),
        .o_q_wr       (w_q_wr),
        .o_q_cmd      (w_q_wr_cmd),
        .i_q_full     (w_q_full)
    );

    cdq_cmd_fifo u_cmdq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (w_q_wr),
        .i_wr_cmd   (w_q_wr_cmd),
        .o_full     (w_q_full),
        .o_rd_valid (w_cmd_valid),
        .o_rd_cmd   (w_cmd),
        .i_rd_pop   (w_cmd_pop)
    );

    cdq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_out_value (o_out_value),
        .o_last      (o_last)
    );

    // a refused request is a single result with a zero value
    a_refused_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_last && o_out_value == '0))
        else $error("refused result not single or value not zero");

    // the back end only takes commands the queue holds
    a_pop_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> w_cmd_valid)
        else $error("command taken from empty queue");

    // a known opcode that is accepted reaches the front register
    a_known_captured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_opcode == OPC_PUSH_HEAD ||
         i_opcode == OPC_PUSH_TAIL || i_opcode == OPC_POP_HEAD ||
         i_opcode == OPC_POP_TAIL || i_opcode == OPC_LIST))
        |=> (w_q_wr || o_in_stall))
        else $error("accepted request lost in front end");

endmodule

### verif/tb_circular_double_ended_queue.sv
`timescale 1ns / 100ps
// Self-checking testbench for circular_double_ended_queue: pushes, pops and lists
// go in under random idling, and a scoreboard predicts and checks every result.
// Depends on cdq_pkg and the circular_double_ended_queue RTL.
module tb_circular_double_ended_queue;
    import cdq_pkg::*;

    localparam int ITEM_COUNT  = 330;
    localparam int HOLD_CYCLES = 150;
    localparam int TAIL_CYCLES = 40;
    localparam int TIMEOUT_NS  = 800_000;

    // opcodes the block drops without a result
    localparam logic [OPC_W-1:0] OPC_UNUSED_FIRST = OPC_LIST + 1'b1;
    localparam logic [OPC_W-1:0] OPC_UNUSED_LAST  = '1;

    typedef struct {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } t_deque_result;

    // Mirror of the deque contents plus the results still owed by the block.
    class deque_scoreboard;
        logic signed [DATA_W-1:0] slot_mem [DEPTH_DEF];
        int unsigned              head_ptr;
        int unsigned              tail_ptr;
        bit                       empty_flag;
        t_deque_result            pending_results [$];
        int                       mismatches;

        function new();
            head_ptr   = 0;
            tail_ptr   = 0;
            empty_flag = 1'b1;
            mismatches = 0;
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        function void add_result(input logic [STATUS_W-1:0] st,
                                 input logic signed [DATA_W-1:0] v, input logic lst);
            t_deque_result r;
            r.status = st;
            r.value  = v;
            r.last   = lst;
            pending_results.push_back(r);
        endfunction

        // Update the mirror for one accepted request and queue its results.
        function void note_request(input logic [OPC_W-1:0] opc,
                                   input logic signed [DATA_W-1:0] val);
            logic signed [DATA_W-1:0] v;
            int unsigned              idx;
            case (opc)
                OPC_PUSH_HEAD, OPC_PUSH_TAIL: begin
                    if (!empty_flag && head_ptr == (tail_ptr + 1) % DEPTH_DEF) begin
                        add_result(ST_FULL, '0, 1'b1);
                    end else begin
                        if (empty_flag) begin
                            head_ptr    = 0;
                            tail_ptr    = 0;
                            empty_flag  = 1'b0;
                            slot_mem[0] = val;
                        end else if (opc == OPC_PUSH_HEAD) begin
                            head_ptr = (head_ptr + DEPTH_DEF - 1) % DEPTH_DEF;
                            slot_mem[head_ptr] = val;
                        end else begin
                            tail_ptr = (tail_ptr + 1) % DEPTH_DEF;
                            slot_mem[tail_ptr] = val;
                        end
                        add_result(ST_OK, '0, 1'b1);
                    end
                end
                OPC_POP_HEAD, OPC_POP_TAIL: begin
                    if (empty_flag) begin
                        add_result(ST_EMPTY, '0, 1'b1);
                    end else begin
                        idx = (opc == OPC_POP_HEAD) ? head_ptr : tail_ptr;
                        v   = slot_mem[idx];
                        // the last entry leaves: empty the queue and rewind both ends
                        if (head_ptr == tail_ptr) begin
                            empty_flag = 1'b1;
                            head_ptr   = 0;
                            tail_ptr   = 0;
                        end else if (opc == OPC_POP_HEAD) begin
                            head_ptr = (head_ptr + 1) % DEPTH_DEF;
                        end else begin
                            tail_ptr = (tail_ptr + DEPTH_DEF - 1) % DEPTH_DEF;
                        end
                        add_result(ST_OK, v, 1'b1);
                    end
                end
                OPC_LIST: begin
                    if (empty_flag) begin
                        add_result(ST_EMPTY, '0, 1'b1);
                    end else begin
                        idx = head_ptr;
                        while (idx != tail_ptr) begin
                            add_result(ST_OK, slot_mem[idx], 1'b0);
                            idx = (idx + 1) % DEPTH_DEF;
                        end
                        add_result(ST_OK, slot_mem[tail_ptr], 1'b1);
                    end
                end
                default: ;
            endcase
        endfunction

        // Compare one accepted result with the oldest owed result.
        function void check_result(input logic [STATUS_W-1:0] st,
                                   input logic signed [DATA_W-1:0] v, input logic lst);
            t_deque_result want;
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result status=%0d value=%0d last=%0b",
                         $time, st, v, lst);
                return;
            end
            want = pending_results.pop_front();
            if (st !== want.status) begin
                mismatches++;
                $display("%0t: status expected %0d actual %0d", $time, want.status, st);
            end
            if (v !== want.value) begin
                mismatches++;
                $display("%0t: value expected %0d actual %0d", $time, want.value, v);
            end
            if (lst !== want.last) begin
                mismatches++;
                $display("%0t: last expected %0b actual %0b", $time, want.last, lst);
            end
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic [OPC_W-1:0]         i_opcode;
    logic signed [DATA_W-1:0] i_push_value;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic [STATUS_W-1:0]      o_status;
    logic signed [DATA_W-1:0] o_out_value;
    logic                     o_last;

    deque_scoreboard sb = new();
    logic            no_idle;
    logic            holdoff_req;
    int              known_sent = 0;

    circular_double_ended_queue #(
        .DEPTH(DEPTH_DEF)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .i_push_value(i_push_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_out_value (o_out_value),
        .o_last      (o_last)
    );

    always #1 i_clk = ~i_clk;

    // Draw a push value, biased toward the extremes.
    function automatic logic signed [DATA_W-1:0] rand_value();
        case ($urandom_range(7))
            0: return {1'b0, {(DATA_W-1){1'b1}}};
            1: return {1'b1, {(DATA_W-1){1'b0}}};
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [OPC_W-1:0] pick_opcode();
        int r;
        r = $urandom_range(99);
        if (r < 22) return OPC_PUSH_HEAD;
        if (r < 44) return OPC_PUSH_TAIL;
        if (r < 62) return OPC_POP_HEAD;
        if (r < 80) return OPC_POP_TAIL;
        if (r < 94) return OPC_LIST;
        return OPC_W'($urandom_range(OPC_UNUSED_FIRST, OPC_UNUSED_LAST));
    endfunction

    // Offer one request, hold it until accepted, then maybe drop valid and idle.
    task automatic send_request(input logic [OPC_W-1:0] opc,
                                input logic signed [DATA_W-1:0] val);
        i_in_valid   <= 1'b1;
        i_opcode     <= opc;
        i_push_value <= val;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(opc, val);
        if (opc <= OPC_LIST) known_sent++;
        if (!no_idle && $urandom_range(99) < 25) begin
            i_in_valid   <= 1'b0;
            i_opcode     <= OPC_W'($urandom);
            i_push_value <= $urandom;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Drop valid and hold off until every owed result has come back.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    // Push from random ends up to or past the capacity, then list the full queue.
    task automatic run_fill_burst();
        int n;
        n = $urandom_range(DEPTH_DEF, DEPTH_DEF + 4);
        for (int k = 0; k < n; k++)
            send_request($urandom_range(1) ? OPC_PUSH_TAIL : OPC_PUSH_HEAD, rand_value());
        send_request(OPC_LIST, rand_value());
    endtask

    // Pop from random ends, usually until the queue runs dry.
    task automatic run_drain_burst();
        int n;
        n = $urandom_range(DEPTH_DEF / 2, DEPTH_DEF + 2);
        for (int k = 0; k < n; k++)
            send_request($urandom_range(1) ? OPC_POP_TAIL : OPC_POP_HEAD, rand_value());
        send_request(OPC_LIST, rand_value());
    endtask

    task automatic run_mixed_burst();
        int n;
        n = $urandom_range(8, 16);
        for (int k = 0; k < n; k++)
            send_request(pick_opcode(), rand_value());
    endtask

    task automatic run_random(input int target);
        while (known_sent < target) begin
            case ($urandom_range(9))
                0, 1:    run_fill_burst();
                2, 3:    run_drain_burst();
                default: run_mixed_burst();
            endcase
        end
    endtask

    // Result side: check accepted results, then pick the stall for the next cycle.
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall)
                sb.check_result(o_status, o_out_value, o_last);
            if (holdoff_req && !hold_done && hold_left == 0) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (no_idle) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(99) < 25);
            end
        end
    end

    // Request side: reset, directed cases, random bursts, back-pressure, drain.
    initial begin
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_opcode     <= '0;
        i_push_value <= '0;
        no_idle      <= 1'b0;
        holdoff_req  <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // pop and list on an empty queue
        send_request(OPC_POP_HEAD, rand_value());
        send_request(OPC_POP_TAIL, rand_value());
        send_request(OPC_LIST, rand_value());
        // dropped opcodes
        for (int k = OPC_UNUSED_FIRST; k <= OPC_UNUSED_LAST; k++)
            send_request(OPC_W'(k), rand_value());
        // push to empty, then grow both ends with extreme values
        send_request(OPC_PUSH_HEAD, {1'b0, {(DATA_W-1){1'b1}}});
        send_request(OPC_PUSH_TAIL, {1'b1, {(DATA_W-1){1'b0}}});
        send_request(OPC_PUSH_HEAD, '0);
        send_request(OPC_PUSH_TAIL, '1);
        send_request(OPC_LIST, rand_value());
        send_request(OPC_UNUSED_LAST, rand_value());
        send_request(OPC_POP_HEAD, rand_value());
        send_request(OPC_POP_TAIL, rand_value());
        send_request(OPC_LIST, rand_value());
        // pop the last two entries, then pop once more on empty
        send_request(OPC_POP_TAIL, rand_value());
        send_request(OPC_POP_HEAD, rand_value());
        send_request(OPC_POP_HEAD, rand_value());
        // head wraps below slot zero
        send_request(OPC_PUSH_TAIL, {(DATA_W/2){2'b01}});
        send_request(OPC_PUSH_HEAD, {(DATA_W/2){2'b10}});
        send_request(OPC_LIST, rand_value());
        send_request(OPC_POP_TAIL, rand_value());
        send_request(OPC_POP_HEAD, rand_value());

        // random bursts, full queue pushes included
        run_random(120);
        no_idle <= 1'b1;
        run_random(200);
        no_idle <= 1'b0;

        // stall the result side long enough to back up the input
        wait_drained();
        holdoff_req <= 1'b1;
        run_fill_burst();
        run_drain_burst();
        wait_drained();

        run_random(ITEM_COUNT);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("Regression FAIL");
        $finish;
    end

endmodule
